>>> sv/tile_majority_label_repair_assert.svh
// Assertion macros shared by the tile majority label repair RTL.
// Needs nothing else; taken in by `include where assertions are written.
`ifndef TILE_MAJORITY_LABEL_REPAIR_ASSERT_SVH
`define TILE_MAJORITY_LABEL_REPAIR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TMLR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tmlr assertion failed");

// next-cycle implication, checked out of reset
`define TMLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tmlr assertion failed");

`endif

>>> sv/tmlr_pkg.sv
// Shared types and constants for the tile majority label repair block.
// No dependencies; used by tmlr_ctrl, tmlr_dp and the top level.
`timescale 1ns / 1ps

package tmlr_pkg;

    localparam int PALETTE_SIZE_DEF = 6;
    localparam int COLOR_W          = 24;
    localparam int CNT_W            = 13;
    localparam int PCNT_W           = 3;
    localparam int CFG_IDX_W        = 3;

    localparam logic [CNT_W-1:0]     CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_0       = 3'd1;

    typedef struct packed {
        logic load_in;
        logic count;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_repair;
    } t_sts;

endpackage

>>> sv/tmlr_ctrl.sv
// Controller for the tile majority label repair block: accept, execute, output valid.
// Depends on tmlr_pkg (command and status structs).
`timescale 1ns / 1ps

module tmlr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    input  tmlr_pkg::t_sts i_sts,
    output tmlr_pkg::t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign out_free      = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state         = r_state;
        n_out_valid     = r_out_valid && !m_axis_tready;
        o_cmd           = '0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_sts.is_repair) begin
                    o_cmd.count = 1'b1;
                    n_state     = S_IDLE;
                end else if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> sv/tmlr_dp.sv
// Datapath for the tile majority label repair block: palette registers,
// per-entry counters, match, majority pick and output register. Depends on tmlr_pkg.
`timescale 1ns / 1ps

module tmlr_dp #(
    parameter int PALETTE_SIZE = tmlr_pkg::PALETTE_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wen,
    input  logic [tmlr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tmlr_pkg::COLOR_W-1:0]   i_cfg_wdata,
    input  logic                           i_action,
    input  logic                           i_first,
    input  logic [tmlr_pkg::COLOR_W-1:0]   i_pixel,
    input  tmlr_pkg::t_cmd                 i_cmd,
    output tmlr_pkg::t_sts                 o_sts,
    output logic [tmlr_pkg::COLOR_W-1:0]   o_out_color,
    output logic                           o_replaced
);

    logic [tmlr_pkg::PCNT_W-1:0]  r_pal_cnt;
    logic [tmlr_pkg::COLOR_W-1:0] r_color [PALETTE_SIZE];
    logic [tmlr_pkg::CNT_W-1:0]   r_cnt   [PALETTE_SIZE];
    logic [tmlr_pkg::CNT_W-1:0]   n_cnt   [PALETTE_SIZE];

    logic                         r_action;
    logic                         r_first;
    logic [tmlr_pkg::COLOR_W-1:0] r_px;
    logic [tmlr_pkg::COLOR_W-1:0] r_out_color, n_out_color;
    logic                         r_out_repl, n_out_repl;

    logic [PALETTE_SIZE-1:0]      in_use;
    logic [PALETTE_SIZE-1:0]      hit;
    logic [PALETTE_SIZE-1:0]      sel;
    logic [PALETTE_SIZE-1:0]      best_oh;
    logic [tmlr_pkg::CNT_W-1:0]   best_cnt;
    logic [tmlr_pkg::COLOR_W-1:0] best_color;
    logic                         taken;

    assign o_sts.is_repair = r_action;
    assign o_out_color     = r_out_color;
    assign o_replaced      = r_out_repl;

    // match against in-use entries; lowest index wins on duplicates
    always_comb begin
        taken = 1'b0;
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            in_use[i] = (i < int'(r_pal_cnt));
            hit[i]    = in_use[i] && (r_color[i] == r_px);
            sel[i]    = hit[i] && !taken;
            taken     = taken || hit[i];
        end
    end

    // majority pick, strict greater keeps the lowest index on ties
    always_comb begin
        best_cnt   = '0;
        best_oh    = '0;
        best_color = '0;
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            if (in_use[i] && (r_cnt[i] > best_cnt)) begin
                best_cnt   = r_cnt[i];
                best_oh    = '0;
                best_oh[i] = 1'b1;
            end
        end
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            best_color = best_color | ({tmlr_pkg::COLOR_W{best_oh[i]}} & r_color[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            n_cnt[i] = r_cnt[i];
            if (i_cmd.count) begin
                if (r_first) begin
                    n_cnt[i] = sel[i] ? tmlr_pkg::CNT_W'(1) : '0;
                end else if (sel[i] && (r_cnt[i] != tmlr_pkg::CNT_MAX)) begin
                    n_cnt[i] = r_cnt[i] + tmlr_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        n_out_color = r_px;
        n_out_repl  = 1'b0;
        if (!taken && (best_cnt != '0)) begin
            n_out_color = best_color;
            n_out_repl  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_cnt <= '0;
            for (int i = 0; i < PALETTE_SIZE; i++) begin
                r_color[i] <= '0;
                r_cnt[i]   <= '0;
            end
        end else begin
            if (i_cfg_wen && (i_cfg_idx == tmlr_pkg::REG_PALETTE_COUNT)) begin
                r_pal_cnt <= i_cfg_wdata[tmlr_pkg::PCNT_W-1:0];
            end
            for (int i = 0; i < PALETTE_SIZE; i++) begin
                if (i_cfg_wen &&
                    (i_cfg_idx == tmlr_pkg::REG_COLOR_0 + tmlr_pkg::CFG_IDX_W'(i))) begin
                    r_color[i] <= i_cfg_wdata;
                end
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_action;
            r_first  <= i_first;
            r_px     <= i_pixel;
        end
        if (i_cmd.load_out) begin
            r_out_color <= n_out_color;
            r_out_repl  <= n_out_repl;
        end
    end

endmodule

>>> sv/tile_majority_label_repair.sv
// Top level of the tile majority label repair block.
// Depends on tmlr_pkg, tmlr_ctrl, tmlr_dp and tile_majority_label_repair_assert.svh.
//
//  channel   | dir | content
//  s_axis    | in  | tdata: pixel_color[23:0]; tuser: action[0], first_of_tile[1]
//  m_axis    | out | tdata: out_color[23:0];   tuser: replaced[0]
//  cfg       | in  | write enable, register index, 24-bit write data
//
// Each pixel is taken in the idle state; the execute state then matches it and
// updates the counters or picks the majority color.
// A repair pixel waits in the execute cycle while the output register holds a result
// that has not been taken; the next pixel is taken once it has moved on.
// Synchronous active-low reset clears palette registers, counters and control.
`timescale 1ns / 1ps
`include "tile_majority_label_repair_assert.svh"

module tile_majority_label_repair #(
    parameter int PALETTE_SIZE = tmlr_pkg::PALETTE_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wen,
    input  logic [tmlr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tmlr_pkg::COLOR_W-1:0]   i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // [23:0] pixel_color
    input  logic [1:0]                     s_axis_tuser,  // [0] action, [1] first_of_tile
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata,  // [23:0] out_color
    output logic [0:0]                     m_axis_tuser   // [0] replaced
);

    tmlr_pkg::t_cmd cmd;
    tmlr_pkg::t_sts sts;

    tmlr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    tmlr_dp #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_action    (s_axis_tuser[0]),
        .i_first     (s_axis_tuser[1]),
        .i_pixel     (s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_color (m_axis_tdata),
        .o_replaced  (m_axis_tuser[0])
    );

    `TMLR_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, cmd.load_out, (!m_axis_tvalid || m_axis_tready))
    `TMLR_ASSERT_NEXT(a_count_no_result, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0]), (!cmd.load_out && cmd.count))
    `TMLR_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready), !s_axis_tready)

endmodule
